### hdl/zunt_pkg.sv
// Shared types, constants and codes for the decision-diagram unique node table.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package zunt_pkg;

    localparam int CHILD_W    = 13;
    localparam int LABEL_IN_W = 20;
    localparam int INDEX_W    = 12;
    localparam int SLOT_MAX_W = 21;
    localparam int QDEPTH     = 2;

    localparam int NODES_DEF      = 4096;
    localparam int HASH_SLOTS_DEF = 8192;
    localparam int LABEL_BITS_DEF = 20;

    localparam logic [31:0]        GOLDEN     = 32'h9e37_79b9;
    localparam logic [CHILD_W-1:0] CODE_EMPTY = 13'h1FFF;
    localparam logic [CHILD_W-1:0] CODE_UNIT  = 13'h1FFE;

    typedef enum logic [1:0] {
        ST_FOUND   = 2'd0,
        ST_CREATED = 2'd1,
        ST_FULL    = 2'd2,
        ST_INVALID = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        F_IDLE,
        F_HASH,
        F_MOD,
        F_PUSH
    } t_fstate;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_BKT,
        B_NODE,
        B_CMP,
        B_OUT
    } t_bstate;

    // One classified request as it travels from the front to the back.
    typedef struct packed {
        logic                     invalid;
        logic [CHILD_W-1:0]       lo;
        logic [CHILD_W-1:0]       hi;
        logic [LABEL_IN_W-1:0]    label;
        logic [SLOT_MAX_W-1:0]    slot;
    } t_job;

endpackage

`default_nettype wire

### hdl/zunt_req_if.sv
// Request channel of the unique node table: valid/ready plus one node triple.
// Depends on zunt_pkg for the field widths.
`default_nettype none

interface zunt_req_if;
    import zunt_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CHILD_W-1:0]    low_child;
    logic [CHILD_W-1:0]    high_child;
    logic [LABEL_IN_W-1:0] node_label;

    modport source (output valid, output low_child, output high_child,
                    output node_label, input ready);
    modport sink   (input valid, input low_child, input high_child,
                    input node_label, output ready);
endinterface

`default_nettype wire

### hdl/zunt_rsp_if.sv
// Response channel of the unique node table: valid/ready plus index and status.
// Depends on zunt_pkg for the field widths.
`default_nettype none

interface zunt_rsp_if;
    import zunt_pkg::*;

    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] node_index;
    logic [1:0]         status;

    modport source (output valid, output node_index, output status, input ready);
    modport sink   (input valid, input node_index, input status, output ready);
endinterface

`default_nettype wire

### hdl/zdd_unique_node_table.sv
// Unique node table for decision diagrams (hash consing of node triples).
// Request channel i_req: low_child, high_child (13-bit signed; -1 empty
// terminal, -2 unit terminal) and node_label. Response channel o_rsp:
// node_index and status (found, created, store full, invalid request).
// Every request gives exactly one response, in request order.
// The front mixes the low child, high child and label into a hash (then takes
// remainder steps when HASH_SLOTS is not a power of two) and hands the triple
// through a two-entry queue to the back, which probes the bucket table: a
// bucket read, a node read and a compare per occupied bucket, and a bucket
// read and node read at the empty bucket, where a new node is appended.
// The front takes no new request until it has pushed the last one into the
// queue; on long chains the back's probe loop limits throughput.
// After reset the back clears all HASH_SLOTS buckets (8192 by default), one
// bucket a cycle; i_req.ready stays low during that pass.
// When the receiver stalls, the response waits in the output register, the
// back stops at its next result and the queue and front fill before
// i_req.ready drops. The node store contents are kept only until reset.
`default_nettype none

module zdd_unique_node_table #(
    parameter int NODES      = zunt_pkg::NODES_DEF,
    parameter int HASH_SLOTS = zunt_pkg::HASH_SLOTS_DEF,
    parameter int LABEL_BITS = zunt_pkg::LABEL_BITS_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    zunt_req_if.sink     i_req,
    zunt_rsp_if.source   o_rsp
);
    import zunt_pkg::*;

    t_job front_job, queue_job;
    logic push, pop, q_full, q_empty, clearing;

    zunt_front #(
        .HASH_SLOTS (HASH_SLOTS),
        .LABEL_BITS (LABEL_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_hold  (clearing),
        .i_req   (i_req),
        .i_full  (q_full),
        .o_push  (push),
        .o_job   (front_job)
    );

    zunt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (queue_job),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    zunt_back #(
        .NODES      (NODES),
        .HASH_SLOTS (HASH_SLOTS),
        .LABEL_BITS (LABEL_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (queue_job),
        .i_empty    (q_empty),
        .o_pop      (pop),
        .o_clearing (clearing),
        .o_rsp      (o_rsp)
    );

endmodule

`default_nettype wire

### hdl/zunt_front.sv
// Front end: accepts a request, checks the child codes and hashes the triple
// to its first bucket. Depends on zunt_pkg and zunt_req_if.
`default_nettype none

module zunt_front #(
    parameter int HASH_SLOTS = zunt_pkg::HASH_SLOTS_DEF,
    parameter int LABEL_BITS = zunt_pkg::LABEL_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_hold,
    zunt_req_if.sink           i_req,
    input  wire logic          i_full,
    output logic               o_push,
    output zunt_pkg::t_job     o_job
);
    import zunt_pkg::*;

    localparam int SW = $clog2(HASH_SLOTS);
    localparam bit POW2 = (HASH_SLOTS & (HASH_SLOTS - 1)) == 0;

    t_fstate r_state, n_state;
    logic [1:0] r_step, n_step;
    logic [31:0] r_seed, n_seed;
    logic [SW:0] r_rem, n_rem;
    logic [CHILD_W-1:0] r_lo, n_lo, r_hi, n_hi;
    logic [LABEL_IN_W-1:0] r_label, n_label;
    logic r_invalid, n_invalid;
    logic [SLOT_MAX_W-1:0] r_slot, n_slot;

    logic accept;
    logic [LABEL_BITS-1:0] lab;
    logic [31:0] mix_v, mix_out;
    logic [SW:0] rem_step;

    function automatic logic child_ok(input logic [CHILD_W-1:0] raw);
        return !raw[CHILD_W-1] || raw == CODE_UNIT || raw == CODE_EMPTY;
    endfunction

    function automatic logic [31:0] mix(input logic [31:0] seed, input logic [31:0] v);
        return seed ^ (v + GOLDEN + (seed << 6) + (seed >> 2));
    endfunction

    assign i_req.ready = (r_state == F_IDLE) && !i_hold;
    assign accept      = i_req.valid && i_req.ready;
    assign lab         = LABEL_BITS'(r_label);

    always_comb begin
        unique case (r_step)
            2'd0:    mix_v = {{(32 - CHILD_W){r_lo[CHILD_W-1]}}, r_lo};
            2'd1:    mix_v = {{(32 - CHILD_W){r_hi[CHILD_W-1]}}, r_hi};
            default: mix_v = 32'(lab);
        endcase
        mix_out = mix(r_seed, mix_v);
    end

    // Eight bits of restoring remainder per cycle, top byte of the seed first.
    always_comb begin
        rem_step = r_rem;
        for (int b = 0; b < 8; b++) begin
            rem_step = {rem_step[SW-1:0], r_seed[31-b]};
            if (rem_step >= (SW+1)'(HASH_SLOTS)) begin
                rem_step = rem_step - (SW+1)'(HASH_SLOTS);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: begin
                if (accept) begin
                    n_state = (!child_ok(i_req.low_child) || !child_ok(i_req.high_child)
                               || i_req.high_child == CODE_EMPTY) ? F_PUSH : F_HASH;
                end
            end
            F_HASH: begin
                if (r_step == 2'd2) begin
                    n_state = POW2 ? F_PUSH : F_MOD;
                end
            end
            F_MOD: begin
                if (r_step == 2'd3) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        n_step    = r_step;
        n_seed    = r_seed;
        n_rem     = r_rem;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_label   = r_label;
        n_invalid = r_invalid;
        n_slot    = r_slot;
        o_push    = 1'b0;
        unique case (r_state)
            F_IDLE: begin
                if (accept) begin
                    n_lo      = i_req.low_child;
                    n_hi      = i_req.high_child;
                    n_label   = i_req.node_label;
                    n_invalid = !child_ok(i_req.low_child) || !child_ok(i_req.high_child)
                                || i_req.high_child == CODE_EMPTY;
                    n_seed    = '0;
                    n_step    = 2'd0;
                    n_slot    = '0;
                end
            end
            F_HASH: begin
                n_seed = mix_out;
                n_step = r_step + 2'd1;
                if (r_step == 2'd2) begin
                    n_step = 2'd0;
                    n_rem  = '0;
                    n_slot = SLOT_MAX_W'(mix_out[SW-1:0]);
                end
            end
            F_MOD: begin
                n_rem  = rem_step;
                n_seed = r_seed << 8;
                n_step = r_step + 2'd1;
                n_slot = SLOT_MAX_W'(rem_step[SW-1:0]);
            end
            F_PUSH: begin
                o_push = !i_full;
            end
            default: ;
        endcase
    end

    assign o_job = '{invalid: r_invalid, lo: r_lo, hi: r_hi, label: r_label, slot: r_slot};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_step  <= 2'd0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_seed    <= n_seed;
        r_rem     <= n_rem;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_label   <= n_label;
        r_invalid <= n_invalid;
        r_slot    <= n_slot;
    end

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (r_invalid || {1'b0, r_slot} < (SLOT_MAX_W+1)'(HASH_SLOTS)))
        else $error("hashed slot outside the bucket table");
    a_hold_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_hold |-> !accept)
        else $error("request taken during the bucket clearing pass");
    a_push_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> (r_state == F_IDLE && !o_push))
        else $error("one request pushed twice");

endmodule

`default_nettype wire

### hdl/zunt_queue.sv
// Two-entry queue of classified requests between the front and the back.
// Depends on zunt_pkg for the job type.
`default_nettype none

module zunt_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire zunt_pkg::t_job  i_job,
    input  wire logic            i_pop,
    output zunt_pkg::t_job       o_job,
    output logic                 o_full,
    output logic                 o_empty
);
    import zunt_pkg::*;

    localparam int PW = $clog2(QDEPTH);

    t_job r_mem [QDEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0] r_cnt;

    assign o_full  = r_cnt == (PW+1)'(QDEPTH);
    assign o_empty = r_cnt == '0;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(QDEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(QDEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (PW+1)'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - (PW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into a full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("pop from an empty queue");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> r_cnt == $past(r_cnt) + (PW+1)'(1))
        else $error("queue count out of step");

endmodule

`default_nettype wire

### hdl/zunt_back.sv
// Back end: clears the bucket table after reset, probes buckets, compares the
// stored triples and appends new nodes. Depends on zunt_pkg and zunt_rsp_if.
`default_nettype none

module zunt_back #(
    parameter int NODES      = zunt_pkg::NODES_DEF,
    parameter int HASH_SLOTS = zunt_pkg::HASH_SLOTS_DEF,
    parameter int LABEL_BITS = zunt_pkg::LABEL_BITS_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire zunt_pkg::t_job  i_job,
    input  wire logic            i_empty,
    output logic                 o_pop,
    output logic                 o_clearing,
    zunt_rsp_if.source           o_rsp
);
    import zunt_pkg::*;

    localparam int SW = $clog2(HASH_SLOTS);
    localparam int CW = $clog2(NODES + 1);
    localparam int NW = $clog2(NODES);
    localparam int PW = $clog2(HASH_SLOTS + 1);
    localparam int EW = 2 * CHILD_W + LABEL_BITS;

    // A bucket holds one plus a node index; zero marks it empty.
    logic [CW-1:0] bkt_mem  [HASH_SLOTS];
    logic [EW-1:0] node_mem [NODES];

    t_bstate r_state, n_state;
    logic [SW-1:0] r_clr, n_clr;
    logic [SW-1:0] r_slot, n_slot;
    logic [PW-1:0] r_probe, n_probe;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_ent, n_ent;
    logic [CHILD_W-1:0] r_lo, n_lo, r_hi, n_hi;
    logic [LABEL_BITS-1:0] r_lab, n_lab;
    logic r_invalid, n_invalid;
    logic [INDEX_W-1:0] r_res_idx, n_res_idx;
    t_status r_res_st, n_res_st;
    logic r_ovalid, n_ovalid;
    logic [INDEX_W-1:0] r_oidx, n_oidx;
    t_status r_ost, n_ost;

    logic [CW-1:0] r_bkt_q;
    logic [EW-1:0] r_node_q;

    logic bkt_we, node_we;
    logic [SW-1:0] bkt_wa;
    logic [CW-1:0] bkt_wd;
    logic [NW-1:0] node_ra;
    logic hit, last_probe, out_free, bkt_empty, store_full;

    assign o_pop      = (r_state == B_IDLE) && !i_empty;
    assign o_clearing = r_state == B_CLEAR;
    assign hit        = r_node_q == {r_lo, r_hi, r_lab};
    assign last_probe = r_probe == PW'(HASH_SLOTS - 1);
    assign out_free   = !r_ovalid || o_rsp.ready;
    assign bkt_empty  = r_bkt_q == '0;
    assign store_full = r_count == CW'(NODES);
    assign node_ra    = NW'(r_bkt_q - CW'(1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_CLEAR: if (r_clr == SW'(HASH_SLOTS - 1)) n_state = B_IDLE;
            B_IDLE: begin
                if (o_pop) begin
                    n_state = i_job.invalid ? B_OUT : B_BKT;
                end
            end
            B_BKT:  n_state = B_NODE;
            B_NODE: n_state = bkt_empty ? B_OUT : B_CMP;
            B_CMP:  n_state = (hit || last_probe) ? B_OUT : B_BKT;
            B_OUT:  if (out_free) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        n_clr     = r_clr;
        n_slot    = r_slot;
        n_probe   = r_probe;
        n_count   = r_count;
        n_ent     = r_ent;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_lab     = r_lab;
        n_invalid = r_invalid;
        n_res_idx = r_res_idx;
        n_res_st  = r_res_st;
        n_ovalid  = r_ovalid && !o_rsp.ready;
        n_oidx    = r_oidx;
        n_ost     = r_ost;
        bkt_we    = 1'b0;
        bkt_wa    = r_slot;
        bkt_wd    = '0;
        node_we   = 1'b0;
        unique case (r_state)
            B_CLEAR: begin
                bkt_we = 1'b1;
                bkt_wa = r_clr;
                n_clr  = r_clr + SW'(1);
            end
            B_IDLE: begin
                if (o_pop) begin
                    n_lo      = i_job.lo;
                    n_hi      = i_job.hi;
                    n_lab     = LABEL_BITS'(i_job.label);
                    n_invalid = i_job.invalid;
                    n_slot    = i_job.slot[SW-1:0];
                    n_probe   = '0;
                    n_res_idx = '0;
                    n_res_st  = ST_INVALID;
                end
            end
            B_NODE: begin
                n_ent = r_bkt_q;
                if (bkt_empty) begin
                    if (store_full) begin
                        n_res_idx = '0;
                        n_res_st  = ST_FULL;
                    end else begin
                        bkt_we    = 1'b1;
                        bkt_wd    = r_count + CW'(1);
                        node_we   = 1'b1;
                        n_count   = r_count + CW'(1);
                        n_res_idx = INDEX_W'(r_count);
                        n_res_st  = ST_CREATED;
                    end
                end
            end
            B_CMP: begin
                if (hit) begin
                    n_res_idx = INDEX_W'(r_ent - CW'(1));
                    n_res_st  = ST_FOUND;
                end else if (last_probe) begin
                    n_res_idx = '0;
                    n_res_st  = ST_FULL;
                end else begin
                    n_probe = r_probe + PW'(1);
                    n_slot  = (r_slot == SW'(HASH_SLOTS - 1)) ? '0 : r_slot + SW'(1);
                end
            end
            B_OUT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_oidx   = r_res_idx;
                    n_ost    = r_res_st;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (bkt_we) begin
            bkt_mem[bkt_wa] <= bkt_wd;
        end
        r_bkt_q <= bkt_mem[r_slot];
    end

    always_ff @(posedge i_clk) begin
        if (node_we) begin
            node_mem[r_count[NW-1:0]] <= {r_lo, r_hi, r_lab};
        end
        r_node_q <= node_mem[node_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_CLEAR;
            r_clr    <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot    <= n_slot;
        r_probe   <= n_probe;
        r_ent     <= n_ent;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_lab     <= n_lab;
        r_invalid <= n_invalid;
        r_res_idx <= n_res_idx;
        r_res_st  <= n_res_st;
        r_oidx    <= n_oidx;
        r_ost     <= n_ost;
    end

    assign o_rsp.valid      = r_ovalid;
    assign o_rsp.node_index = r_oidx;
    assign o_rsp.status     = r_ost;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(NODES))
        else $error("node count beyond the store depth");
    a_zero_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && (r_ost == ST_FULL || r_ost == ST_INVALID)) |-> r_oidx == '0)
        else $error("nonzero index with a failed request");
    a_create_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        node_we |=> (r_count == $past(r_count) + CW'(1) && r_res_st == ST_CREATED))
        else $error("node append out of step with the count");
    a_invalid_direct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_OUT && r_invalid) |-> r_res_st == ST_INVALID)
        else $error("invalid request probed the table");

endmodule

`default_nettype wire

### verif/tb.sv
// Self-checking testbench for the decision-diagram unique node table.
// Uses zunt_pkg and the zunt_req_if / zunt_rsp_if channels; predicts every
// response with its own hash table model or a fixed directed answer, and checks them in order.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import zunt_pkg::*;

    localparam int NODES      = NODES_DEF;
    localparam int HASH_SLOTS = HASH_SLOTS_DEF;
    localparam int RAND_ITEMS = 1530;
    localparam int LIMIT      = 1_000_000;
    localparam int HOLD_LEN   = 400;

    typedef struct packed {
        logic [CHILD_W-1:0]    lo;
        logic [CHILD_W-1:0]    hi;
        logic [LABEL_IN_W-1:0] lab;
    } t_triple;

    typedef struct packed {
        logic [INDEX_W-1:0] idx;
        t_status            st;
    } t_answer;

    typedef struct packed {
        t_triple w;
        logic    typed;
        t_answer ans;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    zunt_req_if req_if();
    zunt_rsp_if rsp_if();

    zdd_unique_node_table u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always #10 i_clk = ~i_clk;

    // Model of the table contents.
    logic [CHILD_W-1:0]    node_lo  [NODES];
    logic [CHILD_W-1:0]    node_hi  [NODES];
    logic [LABEL_IN_W-1:0] node_lab [NODES];
    int unsigned           bucket_ref [HASH_SLOTS];
    int unsigned           node_total = 0;

    t_answer     answers_q [$];
    int          err_count = 0;
    int          rsp_seen = 0;
    int          words_sent = 0;
    int          seen_by_status [4] = '{0, 0, 0, 0};
    int          cycles = 0;
    logic        burst = 1'b0;
    t_row        dir_tab [21];

    function automatic logic [31:0] mix32(logic [31:0] seed, logic [31:0] v);
        return seed ^ (v + GOLDEN + (seed << 6) + (seed >> 2));
    endfunction

    function automatic logic child_legal(logic [CHILD_W-1:0] c);
        return c < 13'h1000 || c == CODE_UNIT || c == CODE_EMPTY;
    endfunction

    // Hash-consing lookup: finds the triple or appends it, as the block does.
    function automatic t_answer unique_lookup(t_triple w);
        logic [31:0] seed;
        int unsigned slot;
        int unsigned ent;
        t_answer     a;
        a.idx = '0;
        a.st  = ST_FULL;
        if (w.hi == CODE_EMPTY || !child_legal(w.lo) || !child_legal(w.hi)) begin
            a.st = ST_INVALID;
            return a;
        end
        seed = mix32(32'd0, {{19{w.lo[CHILD_W-1]}}, w.lo});
        seed = mix32(seed, {{19{w.hi[CHILD_W-1]}}, w.hi});
        seed = mix32(seed, {12'd0, w.lab});
        slot = seed % 32'(HASH_SLOTS);
        for (int n = 0; n < HASH_SLOTS; n++) begin
            ent = bucket_ref[slot];
            if (ent == 0) begin
                if (node_total >= NODES) begin
                    return a;
                end
                node_lo[node_total]  = w.lo;
                node_hi[node_total]  = w.hi;
                node_lab[node_total] = w.lab;
                bucket_ref[slot] = node_total + 1;
                a.idx = INDEX_W'(node_total);
                a.st  = ST_CREATED;
                node_total++;
                return a;
            end
            if (node_lo[ent-1] == w.lo && node_hi[ent-1] == w.hi &&
                node_lab[ent-1] == w.lab) begin
                a.idx = INDEX_W'(ent - 1);
                a.st  = ST_FOUND;
                return a;
            end
            slot = (slot + 1) % HASH_SLOTS;
        end
        return a;
    endfunction

    function automatic t_row row(int lo, int hi, int lab, bit typed, int idx, t_status st);
        t_row r;
        r.w.lo    = CHILD_W'(lo);
        r.w.hi    = CHILD_W'(hi);
        r.w.lab   = LABEL_IN_W'(lab);
        r.typed   = typed;
        r.ans.idx = INDEX_W'(idx);
        r.ans.st  = st;
        return r;
    endfunction

    // Terminals, children that point at stored nodes, or any legal index.
    function automatic logic [CHILD_W-1:0] pick_child(bit low_side);
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return low_side ? CODE_EMPTY : CODE_UNIT;
        if (roll == 1)
            return CODE_UNIT;
        if (roll < 6 && node_total > 0)
            return CHILD_W'($urandom_range(0, node_total - 1));
        return CHILD_W'($urandom_range(0, 4095));
    endfunction

    // roll < 60: new legal triple, < 80: repeat of a stored one,
    // < 90: malformed children, else raw noise on every field.
    function automatic t_triple make_request(int roll);
        t_triple     w;
        int unsigned k;
        w.lo  = pick_child(1'b1);
        w.hi  = pick_child(1'b0);
        w.lab = ($urandom_range(0, 1) == 0) ? LABEL_IN_W'($urandom_range(0, 15))
                                             : LABEL_IN_W'($urandom);
        if (roll >= 60 && roll < 80 && node_total > 0) begin
            k = $urandom_range(0, node_total - 1);
            w.lo  = node_lo[k];
            w.hi  = node_hi[k];
            w.lab = node_lab[k];
        end else if (roll >= 80 && roll < 90) begin
            case ($urandom_range(0, 2))
                0:       w.hi = CODE_EMPTY;
                1:       w.lo = CHILD_W'($urandom_range(13'h1000, 13'h1FFD));
                default: w.hi = CHILD_W'($urandom_range(13'h1000, 13'h1FFD));
            endcase
        end else if (roll >= 90) begin
            w.lo  = CHILD_W'($urandom);
            w.hi  = CHILD_W'($urandom);
            w.lab = LABEL_IN_W'($urandom);
        end
        return w;
    endfunction

    // Entered and left at a falling edge. Gaps hold valid low.
    task automatic send_word(t_triple w, logic typed, t_answer fixed);
        t_answer guess;
        while (!burst && $urandom_range(0, 99) < 28) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.low_child  <= w.lo;
        req_if.high_child <= w.hi;
        req_if.node_label <= w.lab;
        do
            @(posedge i_clk);
        while (!req_if.ready);
        guess = unique_lookup(w);
        answers_q.insert(answers_q.size(), typed ? fixed : guess);
        words_sent++;
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("%0t: timeout with %0d responses outstanding", $time, answers_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            rsp_seen++;
            seen_by_status[rsp_if.status]++;
            if (answers_q.size() == 0) begin
                err_count++;
                $display("%0t: unexpected response index %0d status %0d", $time,
                         rsp_if.node_index, rsp_if.status);
            end else begin
                want = answers_q.pop_front();
                if (rsp_if.node_index !== want.idx) begin
                    err_count++;
                    $display("%0t: node_index expected %0d actual %0d", $time,
                             want.idx, rsp_if.node_index);
                end
                if (rsp_if.status !== want.st) begin
                    err_count++;
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.st, rsp_if.status);
                end
            end
        end
    end

    // Response side: random back-pressure plus one long hold-off that lets
    // the block fill up and drop its request ready.
    initial begin : rsp_side
        int  hold_left;
        bit  held;
        hold_left = 0;
        held      = 1'b0;
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                rsp_if.ready <= 1'b0;
                hold_left--;
            end else if (!held && rsp_seen >= 300) begin
                held = 1'b1;
                hold_left = HOLD_LEN - 1;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= burst || $urandom_range(0, 99) >= 28;
            end
        end
    end

    initial begin : req_side
        t_answer none;
        none = '0;
        for (int i = 0; i < HASH_SLOTS; i++)
            bucket_ref[i] = 0;
        dir_tab = '{
            row(-2, -2, 0, 1, 0, ST_CREATED),
            row(-2, -2, 0, 1, 0, ST_FOUND),
            row(-2, -1, 5, 1, 0, ST_INVALID),
            row(-1, -2, 0, 1, 1, ST_CREATED),
            // Children that are not stored yet are accepted.
            row(4095, 4095, 'hFFFFF, 1, 2, ST_CREATED),
            row(-3, 0, 7, 1, 0, ST_INVALID),
            row(0, -3, 7, 1, 0, ST_INVALID),
            row(-4096, 0, 7, 1, 0, ST_INVALID),
            row(0, -4096, 7, 1, 0, ST_INVALID),
            row(-1, -1, 0, 1, 0, ST_INVALID),
            row(4095, -1, 'hFFFFF, 1, 0, ST_INVALID),
            row(0, 1, 1, 1, 3, ST_CREATED),
            row(4095, 4095, 'hFFFFF, 1, 2, ST_FOUND),
            row(0, 0, 'h80000, 1, 4, ST_CREATED),
            row(2048, 1024, 'h55555, 0, 0, ST_FOUND),
            row(-1, -2, 0, 1, 1, ST_FOUND),
            row(-2, -2, 1, 0, 0, ST_FOUND),
            row('h0FFF, -2, 'hAAAAA, 0, 0, ST_FOUND),
            row(-2, 4095, 'h0F0F0, 0, 0, ST_FOUND),
            row(-1, 4094, 'hFFFFF, 0, 0, ST_FOUND),
            row(-2, -2, 0, 1, 0, ST_FOUND)
        };

        i_rst_n           = 1'b0;
        req_if.valid      = 1'b0;
        req_if.low_child  = '0;
        req_if.high_child = '0;
        req_if.node_label = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_tab[i])
            send_word(dir_tab[i].w, dir_tab[i].typed, dir_tab[i].ans);

        for (int i = 0; i < RAND_ITEMS; i++) begin
            burst = (i >= 700 && i < 900);
            send_word(make_request($urandom_range(0, 99)), 1'b0, none);
        end
        burst = 1'b0;
        req_if.valid <= 1'b0;

        while (answers_q.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("Sent %0d request words: %0d found, %0d created, %0d refused as full,",
                 words_sent, seen_by_status[ST_FOUND], seen_by_status[ST_CREATED],
                 seen_by_status[ST_FULL]);
        $display("%0d rejected as invalid; table holds %0d nodes, one %0d-cycle stall.",
                 seen_by_status[ST_INVALID], node_total, HOLD_LEN);
        if (err_count == 0 && answers_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
